[sv/hspf_pkg.sv]
// hspf_pkg: transaction types, fixed-point constants and saturation helper
// for the soft hydrogen-bond pair force unit; no dependencies
`default_nettype none

package hspf_pkg;

    typedef struct packed {
        logic [31:0] dist_sq;
        logic [15:0] special_scale;
        logic        want_energy;
    } pair_in_t;

    typedef struct packed {
        logic signed [47:0] force_scale;
        logic signed [47:0] pair_energy;
        logic               in_range;
    } pair_out_t;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WELL_DEPTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ  = 1'b1;

    localparam logic [31:0] WELL_DEPTH_RST = 32'd59223572;
    localparam logic [31:0] CUTOFF_SQ_RST  = 32'd268435456;

    localparam logic [31:0] ONE28      = 32'h1000_0000;
    localparam logic [37:0] ONE32_NARROW = 38'h01_0000_0000;

    localparam logic [127:0] RIN_WIDE   = (128'd756 << 28) / 128'd1000;
    localparam logic [127:0] RIN2_WIDE  = (128'd571536 << 28) / 128'd1000000;
    localparam logic [127:0] RIN2X3_WIDE = RIN2_WIDE * 128'd3;
    localparam logic [127:0] DROI_SQ    = 128'd183581399296;
    localparam logic [127:0] DROI_CUBE  = DROI_SQ * 128'd428464;
    localparam logic [127:0] K0_WIDE    = (128'd13716864000000 << 32) / DROI_SQ;
    localparam logic [127:0] KF_WIDE    = (128'd12000000000000000000 << 32) / DROI_CUBE;
    localparam logic [127:0] KE_WIDE    = (128'd1000000000000000000 << 32) / DROI_CUBE;

    localparam logic [27:0] RIN    = RIN_WIDE[27:0];
    localparam logic [27:0] RIN2   = RIN2_WIDE[27:0];
    localparam logic [29:0] RIN2X3 = RIN2X3_WIDE[29:0];
    localparam logic [38:0] K0     = K0_WIDE[38:0];
    localparam logic [39:0] KF     = KF_WIDE[39:0];
    localparam logic [35:0] KE     = KE_WIDE[35:0];

    localparam logic [47:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SAT_NEG = 48'h8000_0000_0000;

    // signed 48-bit result from sign and magnitude, clamped
    function automatic logic signed [47:0] sat48(input logic neg, input logic [63:0] mag);
        logic [47:0] res;
        if (neg) begin
            if (mag > 64'h0000_8000_0000_0000) res = SAT_NEG;
            else res = 48'(64'd0 - mag);
        end else begin
            if (mag > 64'h0000_7FFF_FFFF_FFFF) res = SAT_POS;
            else res = mag[47:0];
        end
        return signed'(res);
    endfunction

endpackage

`default_nettype wire

[sv/hspf_mul.sv]
// hspf_mul: unsigned multiplier built from four registered partial products
// summed into a registered product; no dependencies
`default_nettype none

module hspf_mul #(
    parameter int unsigned AW = 32,
    parameter int unsigned BW = 32
) (
    input  logic            clk,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic [AW+BW-1:0] p
);

    localparam int unsigned PW = AW + BW;
    localparam int unsigned AL = (AW + 1) / 2;
    localparam int unsigned AH = AW - AL;
    localparam int unsigned BL = (BW + 1) / 2;
    localparam int unsigned BH = BW - BL;

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [PW-1:0]    p_reg;

    always_ff @(posedge clk)
    begin
        ll_reg <= a[AL-1:0] * b[BL-1:0];
        lh_reg <= a[AL-1:0] * b[BW-1:BL];
        hl_reg <= a[AW-1:AL] * b[BL-1:0];
        hh_reg <= a[AW-1:AL] * b[BW-1:BL];
    end

    always_ff @(posedge clk)
    begin
        p_reg <= PW'(ll_reg) + (PW'(lh_reg) << BL) + (PW'(hl_reg) << AL)
               + (PW'(hh_reg) << (AL + BL));
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[sv/hbond_soft_pair_force_unit.sv]
// hbond_soft_pair_force_unit: pipelined pair force and energy kernel
// depends on hspf_pkg and hspf_mul
// pipeline: input capture, the 28-step square root, the region-term register, four
//   multiply phases, the divider entry register, the 47-step divider, the output register
// throughput: one transaction per cycle, busy never rises; one root/quotient bit per stage
// reset: asynchronous active-low rst_n clears all valid bits and loads the
//   register reset values; results are never stalled by the receiver
`default_nettype none

module hbond_soft_pair_force_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  hspf_pkg::pair_in_t                   cmd,
    output logic                                 done,
    output hspf_pkg::pair_out_t                  result,
    input  logic                                 cfg_wr_en,
    input  logic [hspf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);

    localparam int SQ_STEPS  = 28;
    localparam int DIV_STEPS = 47;
    localparam int MUL_LAT   = 2;
    localparam int LATENCY   = 1 + SQ_STEPS + 1 + 4 * MUL_LAT + 1 + DIV_STEPS + 1;

    typedef struct packed {
        logic [31:0] d;
        logic [15:0] s;
        logic        we;
        logic        inr;
        logic [27:0] root;
        logic [29:0] rem;
    } sq_t;

    typedef struct packed {
        logic [15:0] s;
        logic        we;
        logic        inr;
        logic        harm;
        logic        fneg;
        logic [27:0] dr;
        logic [39:0] den;
        logic [31:0] a;
        logic [31:0] b;
        logic [33:0] c;
    } prep_t;

    typedef struct packed {
        logic        we;
        logic        inr;
        logic        harm;
        logic        fneg;
        logic [27:0] dr;
        logic [39:0] den;
        logic [33:0] c;
    } m1c_t;

    typedef struct packed {
        m1c_t        k;
        logic [47:0] t1;
        logic [63:0] ab;
        logic [63:0] bb;
    } m2c_t;

    typedef struct packed {
        logic        we;
        logic        inr;
        logic        harm;
        logic        fneg;
        logic        ehneg;
        logic [39:0] den;
        logic [33:0] c;
    } m3c_t;

    typedef struct packed {
        logic        we;
        logic        inr;
        logic        harm;
        logic        fneg;
        logic        ehneg;
        logic [39:0] den;
        logic [87:0] num;
        logic [56:0] fq;
        logic [46:0] emh;
    } m4c_t;

    typedef struct packed {
        logic               inr;
        logic               harm;
        logic               sat;
        logic signed [47:0] force_q;
        logic signed [47:0] energy;
        logic [39:0]        den;
        logic [87:0]        rem;
        logic [46:0]        q;
    } dv_t;

    logic [31:0] well_depth_reg;
    logic [31:0] cutoff_sq_reg;

    logic        s0_vld_reg;
    sq_t         s0_reg;
    sq_t         sq_reg [SQ_STEPS];
    logic [SQ_STEPS-1:0] sq_vld_reg;

    prep_t       prep_next;
    prep_t       prep_reg;
    logic        prep_vld_reg;

    m1c_t        m1c_next;
    m1c_t        m1c_reg [MUL_LAT];
    logic [MUL_LAT-1:0] m1_vld_reg;
    logic [47:0] m1_t1p;
    logic [55:0] m1_dr2p;
    logic [63:0] m1_abp;
    logic [63:0] m1_bbp;

    m2c_t        m2c_next;
    m2c_t        m2c_reg [MUL_LAT];
    logic [MUL_LAT-1:0] m2_vld_reg;
    logic [86:0] m2_t2p;
    logic [87:0] m2_up;
    logic [83:0] m2_vp;
    logic [94:0] m2_gp;

    logic [37:0] m3_g;
    logic [37:0] m3_h;
    m3c_t        m3c_next;
    m3c_t        m3c_reg [MUL_LAT];
    logic [MUL_LAT-1:0] m3_vld_reg;
    logic [75:0] m3_nump;
    logic [112:0] m3_fqp;
    logic [108:0] m3_e1p;
    logic [85:0] m3_ehp;

    m4c_t        m4c_next;
    m4c_t        m4c_reg [MUL_LAT];
    logic [MUL_LAT-1:0] m4_vld_reg;
    logic [86:0] m4_eqp;

    dv_t         d0_next;
    dv_t         d0_reg;
    logic        d0_vld_reg;
    dv_t         dv_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_vld_reg;

    hspf_pkg::pair_out_t out_next;
    hspf_pkg::pair_out_t out_reg;
    logic        done_reg;

    assign busy = 1'b0;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            well_depth_reg <= hspf_pkg::WELL_DEPTH_RST;
            cutoff_sq_reg  <= hspf_pkg::CUTOFF_SQ_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hspf_pkg::CFG_WELL_DEPTH: well_depth_reg <= cfg_data;
                hspf_pkg::CFG_CUTOFF_SQ:  cutoff_sq_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        s0_reg.d    <= cmd.dist_sq;
        s0_reg.s    <= cmd.special_scale;
        s0_reg.we   <= cmd.want_energy;
        s0_reg.inr  <= cmd.dist_sq < cutoff_sq_reg;
        s0_reg.root <= '0;
        s0_reg.rem  <= '0;
    end

    // valid bits for every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg   <= 1'b0;
            sq_vld_reg   <= '0;
            prep_vld_reg <= 1'b0;
            m1_vld_reg   <= '0;
            m2_vld_reg   <= '0;
            m3_vld_reg   <= '0;
            m4_vld_reg   <= '0;
            d0_vld_reg   <= 1'b0;
            dv_vld_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s0_vld_reg   <= start && !busy;
            sq_vld_reg   <= {sq_vld_reg[SQ_STEPS-2:0], s0_vld_reg};
            prep_vld_reg <= sq_vld_reg[SQ_STEPS-1];
            m1_vld_reg   <= {m1_vld_reg[MUL_LAT-2:0], prep_vld_reg};
            m2_vld_reg   <= {m2_vld_reg[MUL_LAT-2:0], m1_vld_reg[MUL_LAT-1]};
            m3_vld_reg   <= {m3_vld_reg[MUL_LAT-2:0], m2_vld_reg[MUL_LAT-1]};
            m4_vld_reg   <= {m4_vld_reg[MUL_LAT-2:0], m3_vld_reg[MUL_LAT-1]};
            d0_vld_reg   <= m4_vld_reg[MUL_LAT-1];
            dv_vld_reg   <= {dv_vld_reg[DIV_STEPS-2:0], d0_vld_reg};
            done_reg     <= dv_vld_reg[DIV_STEPS-1];
        end
    end

    // square root of dist_sq[27:0] << 28, two radicand bits per stage
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        sq_t         prv;
        sq_t         stg_next;
        logic [55:0] x;
        logic [31:0] work;
        logic [31:0] trial;

        if (i == 0)
        begin : g_first
            assign prv = s0_reg;
        end
        else
        begin : g_rest
            assign prv = sq_reg[i-1];
        end

        assign x     = {prv.d[27:0], 28'd0};
        assign work  = {prv.rem, x[2*(SQ_STEPS-1-i) +: 2]};
        assign trial = {2'b00, prv.root, 2'b01};

        always_comb
        begin
            stg_next = prv;
            if (work >= trial)
            begin
                stg_next.rem  = 30'(work - trial);
                stg_next.root = {prv.root[26:0], 1'b1};
            end
            else
            begin
                stg_next.rem  = work[29:0];
                stg_next.root = {prv.root[26:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[i] <= stg_next;
        end
    end

    // region terms
    always_comb
    begin
        logic [31:0] d;
        logic [27:0] r;
        logic [34:0] c_wide;
        d = sq_reg[SQ_STEPS-1].d;
        r = sq_reg[SQ_STEPS-1].root;
        c_wide = 35'(hspf_pkg::ONE28) + {2'b00, d, 1'b0} - 35'(hspf_pkg::RIN2X3);
        prep_next.s    = sq_reg[SQ_STEPS-1].s;
        prep_next.we   = sq_reg[SQ_STEPS-1].we;
        prep_next.inr  = sq_reg[SQ_STEPS-1].inr;
        prep_next.harm = d < {4'd0, hspf_pkg::RIN2};
        prep_next.fneg = d < hspf_pkg::ONE28;
        prep_next.dr   = (hspf_pkg::RIN > r) ? hspf_pkg::RIN - r : '0;
        prep_next.den  = {r, 12'd1};
        prep_next.a    = d - {4'd0, hspf_pkg::RIN2};
        prep_next.b    = (d < hspf_pkg::ONE28) ? hspf_pkg::ONE28 - d : d - hspf_pkg::ONE28;
        prep_next.c    = c_wide[33:0];
    end

    always_ff @(posedge clk)
    begin
        prep_reg <= prep_next;
    end

    // multiply phase 1
    hspf_mul #(.AW(16), .BW(32)) u_m1_t1 (.clk(clk), .a(prep_reg.s), .b(well_depth_reg),
                                           .p(m1_t1p));
    hspf_mul #(.AW(28), .BW(28)) u_m1_dr2 (.clk(clk), .a(prep_reg.dr), .b(prep_reg.dr),
                                            .p(m1_dr2p));
    hspf_mul #(.AW(32), .BW(32)) u_m1_ab (.clk(clk), .a(prep_reg.a), .b(prep_reg.b),
                                           .p(m1_abp));
    hspf_mul #(.AW(32), .BW(32)) u_m1_bb (.clk(clk), .a(prep_reg.b), .b(prep_reg.b),
                                           .p(m1_bbp));

    always_comb
    begin
        m1c_next.we   = prep_reg.we;
        m1c_next.inr  = prep_reg.inr;
        m1c_next.harm = prep_reg.harm;
        m1c_next.fneg = prep_reg.fneg;
        m1c_next.dr   = prep_reg.dr;
        m1c_next.den  = prep_reg.den;
        m1c_next.c    = prep_reg.c;
    end

    always_ff @(posedge clk)
    begin
        m1c_reg[0] <= m1c_next;
        m1c_reg[1] <= m1c_reg[0];
    end

    // multiply phase 2
    hspf_mul #(.AW(48), .BW(39)) u_m2_t2 (.clk(clk), .a(m1_t1p), .b(hspf_pkg::K0),
                                           .p(m2_t2p));
    hspf_mul #(.AW(48), .BW(40)) u_m2_u (.clk(clk), .a(m1_t1p), .b(hspf_pkg::KF),
                                          .p(m2_up));
    hspf_mul #(.AW(48), .BW(36)) u_m2_v (.clk(clk), .a(m1_t1p), .b(hspf_pkg::KE),
                                          .p(m2_vp));
    hspf_mul #(.AW(39), .BW(56)) u_m2_g (.clk(clk), .a(hspf_pkg::K0), .b(m1_dr2p),
                                          .p(m2_gp));

    always_comb
    begin
        m2c_next.k  = m1c_reg[MUL_LAT-1];
        m2c_next.t1 = m1_t1p;
        m2c_next.ab = m1_abp;
        m2c_next.bb = m1_bbp;
    end

    always_ff @(posedge clk)
    begin
        m2c_reg[0] <= m2c_next;
        m2c_reg[1] <= m2c_reg[0];
    end

    // multiply phase 3
    assign m3_g = m2_gp[94:57];
    assign m3_h = (m3_g >= hspf_pkg::ONE32_NARROW) ? m3_g - hspf_pkg::ONE32_NARROW
                                                    : hspf_pkg::ONE32_NARROW - m3_g;

    hspf_mul #(.AW(48), .BW(28)) u_m3_num (.clk(clk), .a(m2_t2p[86:39]),
                                            .b(m2c_reg[MUL_LAT-1].k.dr), .p(m3_nump));
    hspf_mul #(.AW(49), .BW(64)) u_m3_fq (.clk(clk), .a(m2_up[87:39]),
                                           .b(m2c_reg[MUL_LAT-1].ab), .p(m3_fqp));
    hspf_mul #(.AW(45), .BW(64)) u_m3_e1 (.clk(clk), .a(m2_vp[83:39]),
                                           .b(m2c_reg[MUL_LAT-1].bb), .p(m3_e1p));
    hspf_mul #(.AW(48), .BW(38)) u_m3_eh (.clk(clk), .a(m2c_reg[MUL_LAT-1].t1),
                                           .b(m3_h), .p(m3_ehp));

    always_comb
    begin
        m3c_next.we    = m2c_reg[MUL_LAT-1].k.we;
        m3c_next.inr   = m2c_reg[MUL_LAT-1].k.inr;
        m3c_next.harm  = m2c_reg[MUL_LAT-1].k.harm;
        m3c_next.fneg  = m2c_reg[MUL_LAT-1].k.fneg;
        m3c_next.ehneg = m3_g < hspf_pkg::ONE32_NARROW;
        m3c_next.den   = m2c_reg[MUL_LAT-1].k.den;
        m3c_next.c     = m2c_reg[MUL_LAT-1].k.c;
    end

    always_ff @(posedge clk)
    begin
        m3c_reg[0] <= m3c_next;
        m3c_reg[1] <= m3c_reg[0];
    end

    // multiply phase 4
    hspf_mul #(.AW(53), .BW(34)) u_m4_eq (.clk(clk), .a(m3_e1p[108:56]),
                                           .b(m3c_reg[MUL_LAT-1].c), .p(m4_eqp));

    always_comb
    begin
        m4c_next.we    = m3c_reg[MUL_LAT-1].we;
        m4c_next.inr   = m3c_reg[MUL_LAT-1].inr;
        m4c_next.harm  = m3c_reg[MUL_LAT-1].harm;
        m4c_next.fneg  = m3c_reg[MUL_LAT-1].fneg;
        m4c_next.ehneg = m3c_reg[MUL_LAT-1].ehneg;
        m4c_next.den   = m3c_reg[MUL_LAT-1].den;
        m4c_next.num   = {m3_nump, 12'd0};
        m4c_next.fq    = m3_fqp[112:56];
        m4c_next.emh   = m3_ehp[85:39];
    end

    always_ff @(posedge clk)
    begin
        m4c_reg[0] <= m4c_next;
        m4c_reg[1] <= m4c_reg[0];
    end

    // result saturation and divider entry
    always_comb
    begin
        m4c_t        k;
        logic [58:0] emq;
        k   = m4c_reg[MUL_LAT-1];
        emq = m4_eqp[86:28];
        d0_next.inr     = k.inr;
        d0_next.harm    = k.harm;
        d0_next.sat     = k.num >= {1'b0, k.den, 47'd0};
        d0_next.force_q = hspf_pkg::sat48(k.fneg && (k.fq != '0), {7'd0, k.fq});
        if (!k.we)
            d0_next.energy = '0;
        else if (k.harm)
            d0_next.energy = hspf_pkg::sat48(k.ehneg && (k.emh != '0), {17'd0, k.emh});
        else
            d0_next.energy = hspf_pkg::sat48(emq != '0, {5'd0, emq});
        d0_next.den = k.den;
        d0_next.rem = k.num;
        d0_next.q   = '0;
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        dv_t         prv;
        dv_t         stg_next;
        logic [87:0] sh;

        if (i == 0)
        begin : g_first
            assign prv = d0_reg;
        end
        else
        begin : g_rest
            assign prv = dv_reg[i-1];
        end

        assign sh = 88'(prv.den) << (DIV_STEPS - 1 - i);

        always_comb
        begin
            stg_next = prv;
            if (!prv.sat && (prv.rem >= sh))
            begin
                stg_next.rem = prv.rem - sh;
                stg_next.q[DIV_STEPS-1-i] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[i] <= stg_next;
        end
    end

    // output select
    always_comb
    begin
        dv_t f;
        f = dv_reg[DIV_STEPS-1];
        out_next.in_range = f.inr;
        if (!f.inr)
        begin
            out_next.force_scale = '0;
            out_next.pair_energy = '0;
        end
        else
        begin
            if (f.harm)
                out_next.force_scale = f.sat ? signed'(hspf_pkg::SAT_POS)
                                             : signed'({1'b0, f.q});
            else
                out_next.force_scale = f.force_q;
            out_next.pair_energy = f.energy;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transaction result missing after pipeline latency");

    a_no_energy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cmd.want_energy) |-> ##LATENCY (result.pair_energy == '0))
        else $error("energy not requested but nonzero");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.in_range) |-> (result.force_scale == '0 && result.pair_energy == '0))
        else $error("out of range result not zero");

    a_harm_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.dist_sq < {4'd0, hspf_pkg::RIN2}))
            |-> ##LATENCY !result.force_scale[47])
        else $error("harmonic force negative");
`endif

endmodule

`default_nettype wire
